// File: design/bpfb_pkg.sv
// shared types and constants for the bimodal predictor with fifo target buffer
package bpfb_pkg;

  // two-bit saturating counter codes
  localparam logic [1:0] CTR_MIN        = 2'd0;
  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CTR_MAX        = 2'd3;

  // one resolved branch request
  typedef struct packed {
    logic [31:0] branch_address;
    logic [31:0] branch_target;
    logic [31:0] next_address;
  } branch_req_t;

  // target buffer lookup answer
  typedef struct packed {
    logic [31:0] pred_target;
    logic [4:0]  tracked;
  } btb_resp_t;

endpackage

// File: design/bpfb_ram.sv
// generic single write port ram with registered read
module bpfb_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bpfb_index.sv
// input register and counter index pipeline: (address >> 2) mod table size
module bpfb_index import bpfb_pkg::*; #(
  parameter int COUNTER_ENTRIES = 1024,
  localparam int IW = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  branch_req_t in_req,
  output logic        out_valid,
  output branch_req_t out_req,
  output logic [IW-1:0] out_idx
);

  // reciprocal of the table size scaled by 2^30, quotient estimate is low by at most one
  localparam logic [30:0] RECIP = 31'((64'd1 << 30) / COUNTER_ENTRIES);
  localparam logic [16:0] CNT   = 17'(COUNTER_ENTRIES);

  logic        p0_valid;
  branch_req_t p0_req;
  logic        p1_valid;
  branch_req_t p1_req;
  logic [60:0] p1_prod;
  logic        p2_valid;
  branch_req_t p2_req;
  logic [46:0] p2_qn;

  logic [29:0] rem;
  logic [29:0] idx_full;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p0_valid <= in_valid;
      p1_valid <= p0_valid;
      p2_valid <= p1_valid;
    end
  end

  // payload pipeline with the two multiplications
  always_ff @(posedge clk) begin
    p0_req  <= in_req;
    p1_req  <= p0_req;
    p1_prod <= 61'(p0_req.branch_address[31:2]) * 61'(RECIP);
    p2_req  <= p1_req;
    p2_qn   <= 47'(p1_prod[59:30]) * 47'(CNT);
  end

  // remainder with one correction step
  always_comb begin
    rem      = p2_req.branch_address[31:2] - p2_qn[29:0];
    idx_full = (rem >= 30'(COUNTER_ENTRIES)) ? rem - 30'(COUNTER_ENTRIES) : rem;
  end

  assign out_valid = p2_valid;
  assign out_req   = p2_req;
  assign out_idx   = idx_full[IW-1:0];

endmodule

// File: design/bpfb_btb.sv
// fifo-replaced branch target buffer: parallel lookup, allocate and update
module bpfb_btb import bpfb_pkg::*; #(
  parameter int BUFFER_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  branch_req_t req,
  input  logic        taken,
  output btb_resp_t   resp
);

  localparam int SW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
  localparam int FW = $clog2(BUFFER_ENTRIES + 1);

  logic [31:0] entry_address [BUFFER_ENTRIES];
  logic [31:0] entry_target  [BUFFER_ENTRIES];
  logic [FW-1:0] fill;
  logic [SW-1:0] oldest;

  logic [BUFFER_ENTRIES-1:0] match;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic [31:0]   hit_target;
  logic          full;
  logic [SW-1:0] slot;
  logic [FW-1:0] fill_next;
  logic [SW-1:0] oldest_next;

  // compare against valid entries, addresses are unique so or-reduce the hit
  always_comb begin
    hit_slot   = '0;
    hit_target = '0;
    for (int s = 0; s < BUFFER_ENTRIES; s++) begin
      match[s] = (FW'(s) < fill) && (entry_address[s] == req.branch_address);
      if (match[s]) begin
        hit_slot   = hit_slot | SW'(s);
        hit_target = hit_target | entry_target[s];
      end
    end
    hit = |match;
  end

  // slot choice and fill / oldest pointer update
  always_comb begin
    full        = (fill == FW'(BUFFER_ENTRIES));
    slot        = hit ? hit_slot : (full ? oldest : SW'(fill));
    fill_next   = (!hit && !full) ? fill + 1'b1 : fill;
    oldest_next = oldest;
    if (!hit && full) begin
      oldest_next = (oldest == SW'(BUFFER_ENTRIES - 1)) ? '0 : oldest + 1'b1;
    end
    resp.pred_target = hit ? hit_target : '0;
    resp.tracked     = 5'(fill_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      oldest <= '0;
    end else if (upd) begin
      fill   <= fill_next;
      oldest <= oldest_next;
    end
  end

  // entry storage, a new entry takes the branch target if taken and target zero otherwise
  always_ff @(posedge clk) begin
    if (upd && !hit) begin
      entry_address[slot] <= req.branch_address;
    end
    if (upd && (!hit || taken)) begin
      entry_target[slot] <= taken ? req.branch_target : '0;
    end
  end

endmodule

// File: design/bimodal_predictor_with_fifo_btb.sv
// bimodal branch predictor with 2-bit counters and a fifo target buffer
// path: input register p0, multiplier stages p1 and p2, counter ram read with work stage p3, then the done register
// throughput: one request per cycle while busy is low, fixed by the counter ram read-modify-write with forwarding
// results cannot be held off; each is shown for one cycle under done
// reset: busy stays high while every counter ram entry is swept to weakly taken
// target buffer entries are emptied at once by clearing the fill count
module bimodal_predictor_with_fifo_btb import bpfb_pkg::*; #(
  parameter int COUNTER_ENTRIES = 1024,
  parameter int BUFFER_ENTRIES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] branch_address,
  input  logic [31:0] branch_target,
  input  logic [31:0] next_address,
  output logic        done,
  output logic        predicted_taken,
  output logic [31:0] predicted_target,
  output logic        direction_mispredict,
  output logic        redirect,
  output logic [4:0]  tracked_count
);

  localparam int IW = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1;

  logic          clearing;
  logic [IW-1:0] clr_addr;

  branch_req_t   in_req;
  logic          idx_valid;
  branch_req_t   idx_req;
  logic [IW-1:0] idx;

  logic          p3_valid;
  branch_req_t   p3_req;
  logic [IW-1:0] p3_idx;

  logic          fwd_valid;
  logic [IW-1:0] fwd_idx;
  logic [1:0]    fwd_ctr;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [1:0]    ram_rdata;

  logic       [1:0] ctr;
  logic       [1:0] ctr_next;
  logic             pred;
  logic             taken;
  btb_resp_t        resp;

  assign busy = clearing;
  assign in_req.branch_address = branch_address;
  assign in_req.branch_target  = branch_target;
  assign in_req.next_address   = next_address;

  // index computation stages
  bpfb_index #(.COUNTER_ENTRIES(COUNTER_ENTRIES)) u_index (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !clearing),
    .in_req    (in_req),
    .out_valid (idx_valid),
    .out_req   (idx_req),
    .out_idx   (idx)
  );

  // counter table clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IW'(COUNTER_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // counter ram, read address comes straight from the index stage
  assign ram_we    = clearing || p3_valid;
  assign ram_waddr = clearing ? clr_addr : p3_idx;
  assign ram_wdata = clearing ? CTR_WEAK_TAKEN : ctr_next;

  bpfb_ram #(.WIDTH(2), .DEPTH(COUNTER_ENTRIES)) u_ctr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // work stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      p3_valid  <= idx_valid;
      fwd_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_req  <= idx_req;
    p3_idx  <= idx;
    fwd_idx <= p3_idx;
    fwd_ctr <= ctr_next;
  end

  // counter read with forwarding of the write that raced the ram read
  always_comb begin
    ctr   = (fwd_valid && (fwd_idx == p3_idx)) ? fwd_ctr : ram_rdata;
    pred  = (ctr >= CTR_WEAK_TAKEN);
    taken = (p3_req.next_address == p3_req.branch_target);
    if (taken) begin
      ctr_next = (ctr == CTR_MAX) ? ctr : ctr + 1'b1;
    end else begin
      ctr_next = (ctr == CTR_MIN) ? ctr : ctr - 1'b1;
    end
  end

  // target buffer
  bpfb_btb #(.BUFFER_ENTRIES(BUFFER_ENTRIES)) u_btb (
    .clk   (clk),
    .rst   (rst),
    .upd   (p3_valid),
    .req   (p3_req),
    .taken (taken),
    .resp  (resp)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p3_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    predicted_taken      <= pred;
    predicted_target     <= resp.pred_target;
    direction_mispredict <= (pred != taken);
    redirect             <= !((pred && (p3_req.next_address == resp.pred_target)) ||
                              (!pred && !taken));
    tracked_count        <= resp.tracked;
  end

endmodule

// File: design/bpfb_chk.sv
// port-level checker for the bimodal predictor, bound to the top level
module bpfb_chk #(
  parameter int BUFFER_ENTRIES = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        predicted_taken,
  input logic        direction_mispredict,
  input logic        redirect,
  input logic [4:0]  tracked_count
);

  // no result while the counter table is being swept
  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while busy");

  // every result comes from an earlier request accepted while not busy
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without matching request");

  // a not-taken prediction redirects exactly when the direction was wrong
  a_redirect_not_taken: assert property (@(posedge clk) disable iff (rst)
    (done && !predicted_taken) |-> (redirect == direction_mispredict))
    else $error("redirect inconsistent with not-taken prediction");

  // after a request the buffer holds at least one and at most all entries
  a_tracked_range: assert property (@(posedge clk) disable iff (rst)
    (done && (BUFFER_ENTRIES < 32)) |->
      ((tracked_count != 5'd0) && (int'(tracked_count) <= BUFFER_ENTRIES)))
    else $error("tracked count out of range");

endmodule

bind bimodal_predictor_with_fifo_btb bpfb_chk #(.BUFFER_ENTRIES(BUFFER_ENTRIES)) u_bpfb_chk (
  .clk                  (clk),
  .rst                  (rst),
  .start                (start),
  .busy                 (busy),
  .done                 (done),
  .predicted_taken      (predicted_taken),
  .direction_mispredict (direction_mispredict),
  .redirect             (redirect),
  .tracked_count        (tracked_count)
);
